>>> rtl/oets_pkg.sv
// Shared types and constants for the odd-even transposition sorter.
// Depends on nothing; every other file refers to it by scoped names.
package oets_pkg;

    localparam int CELL_COUNT = 16;
    localparam int VALUE_W    = 32;
    localparam int COUNT_W    = $clog2(CELL_COUNT + 1);
    localparam int PHASE_W    = $clog2(CELL_COUNT);

    localparam logic signed [VALUE_W-1:0] MOST_NEG = {1'b1, {(VALUE_W-1){1'b0}}};

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT_IN,
        CELL_SORT,
        CELL_SHIFT_OUT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     parity;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_EMIT
    } state_t;

endpackage

>>> rtl/oets_if.sv
// Valid/ready channel interfaces for sorter inputs and sorted results.
// Depends on oets_pkg for the value width.
interface oets_item_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [oets_pkg::VALUE_W-1:0]  item_value;
    logic                                 item_last;

    modport source (output valid, output item_value, output item_last, input ready);
    modport sink   (input valid, input item_value, input item_last, output ready);
endinterface

interface oets_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [oets_pkg::VALUE_W-1:0]  sorted_value;
    logic                                 sorted_last;

    modport source (output valid, output sorted_value, output sorted_last, input ready);
    modport sink   (input valid, input sorted_value, input sorted_last, output ready);
endinterface

>>> rtl/odd_even_transposition_sorter.sv
// Top level of the odd-even transposition sorter: sequencer, cell chain
// and output register. Depends on oets_pkg, oets_if and oets_cell.
//
// Usage:
//   items   : valid/ready sink carrying item_value and item_last. Values shift
//             into a chain of CELL_COUNT cells; values past a full chain drop.
//   results : valid/ready source carrying sorted_value and sorted_last.
//   An item with item_last closes the set. The chain then runs CELL_COUNT
//   compare-exchange phases, one per cycle, alternating even and odd pairs.
//   The loaded values then leave largest first, one per cycle while results
//   are taken, from the head cell while the chain shifts toward it;
//   sorted_last marks the final one. The first result enters the output
//   register once the sort phases are done.
// Items are refused during sort and emit; the next set loads as soon as the
//   final result enters the output register.
// Stall: a result waits in the output register and the chain holds.
// Reset: all cells return to the most negative value, counters clear, and
//   the block is ready for a new set.
module odd_even_transposition_sorter
(
    input  logic               clk,
    input  logic               rst_n,
    oets_item_if.sink          items,
    oets_result_if.source      results
);

    oets_pkg::state_t                      state_reg;
    oets_pkg::state_t                      state_next;
    logic [oets_pkg::COUNT_W-1:0]          count_reg;
    logic [oets_pkg::COUNT_W-1:0]          count_next;
    logic [oets_pkg::PHASE_W-1:0]          phase_reg;
    logic [oets_pkg::PHASE_W-1:0]          phase_next;
    oets_pkg::cell_ctrl_t                  ctrl;
    logic                                  emit;

    logic                                  out_valid_reg;
    logic signed [oets_pkg::VALUE_W-1:0]   out_value_reg;
    logic                                  out_last_reg;

    logic signed [oets_pkg::VALUE_W-1:0]   cell_value [oets_pkg::CELL_COUNT];

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        phase_next  = phase_reg;
        ctrl.op     = oets_pkg::CELL_HOLD;
        ctrl.parity = phase_reg[0];
        emit        = 1'b0;
        items.ready = (state_reg == oets_pkg::ST_LOAD);
        unique case (state_reg)
            oets_pkg::ST_LOAD:
            begin
                if (items.valid)
                begin
                    if (count_reg < oets_pkg::COUNT_W'(oets_pkg::CELL_COUNT))
                    begin
                        ctrl.op    = oets_pkg::CELL_SHIFT_IN;
                        count_next = count_reg + 1'b1;
                    end
                    if (items.item_last)
                    begin
                        state_next = oets_pkg::ST_SORT;
                        phase_next = '0;
                    end
                end
            end
            oets_pkg::ST_SORT:
            begin
                ctrl.op = oets_pkg::CELL_SORT;
                if (phase_reg == oets_pkg::PHASE_W'(oets_pkg::CELL_COUNT - 1))
                begin
                    state_next = oets_pkg::ST_EMIT;
                    phase_next = '0;
                end
                else
                    phase_next = phase_reg + 1'b1;
            end
            oets_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    emit       = 1'b1;
                    ctrl.op    = oets_pkg::CELL_SHIFT_OUT;
                    count_next = count_reg - 1'b1;
                    if (count_reg == oets_pkg::COUNT_W'(1))
                        state_next = oets_pkg::ST_LOAD;
                end
            end
            default:
                state_next = oets_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= oets_pkg::ST_LOAD;
            count_reg     <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            phase_reg <= phase_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_value_reg <= cell_value[0];
            out_last_reg  <= (count_reg == oets_pkg::COUNT_W'(1));
        end
    end

    for (genvar i = 0; i < oets_pkg::CELL_COUNT; i++)
    begin : g_cell
        logic signed [oets_pkg::VALUE_W-1:0] left_in;
        logic signed [oets_pkg::VALUE_W-1:0] right_in;

        if (i == 0)
        begin : g_head
            assign left_in = items.item_value;
        end
        else
        begin : g_body
            assign left_in = cell_value[i-1];
        end

        if (i == oets_pkg::CELL_COUNT - 1)
        begin : g_tail
            assign right_in = oets_pkg::MOST_NEG;
        end
        else
        begin : g_inner
            assign right_in = cell_value[i+1];
        end

        oets_cell u_cell
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .pos_odd     (1'((i % 2) == 1)),
            .at_head     (1'(i == 0)),
            .at_tail     (1'(i == oets_pkg::CELL_COUNT - 1)),
            .left_value  (left_in),
            .right_value (right_in),
            .value       (cell_value[i])
        );
    end

    assign results.valid        = out_valid_reg;
    assign results.sorted_value = out_value_reg;
    assign results.sorted_last  = out_last_reg;

endmodule

>>> rtl/oets_cell.sv
// One sorter cell: holds a value, shifts it along the chain or
// compare-exchanges it with a neighbor. Depends on oets_pkg.
module oets_cell
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  oets_pkg::cell_ctrl_t                 ctrl,
    input  logic                                 pos_odd,
    input  logic                                 at_head,
    input  logic                                 at_tail,
    input  logic signed [oets_pkg::VALUE_W-1:0]  left_value,
    input  logic signed [oets_pkg::VALUE_W-1:0]  right_value,
    output logic signed [oets_pkg::VALUE_W-1:0]  value
);

    logic signed [oets_pkg::VALUE_W-1:0] value_reg;
    logic signed [oets_pkg::VALUE_W-1:0] value_next;
    logic                                left_role;

    assign left_role = (pos_odd == ctrl.parity);

    always_comb
    begin
        value_next = value_reg;
        unique case (ctrl.op)
            oets_pkg::CELL_HOLD:      value_next = value_reg;
            oets_pkg::CELL_SHIFT_IN:  value_next = left_value;
            oets_pkg::CELL_SHIFT_OUT: value_next = right_value;
            oets_pkg::CELL_SORT:
            begin
                // left of a pair keeps the larger, right keeps the smaller
                if (left_role)
                begin
                    if (!at_tail && (right_value > value_reg))
                        value_next = right_value;
                end
                else
                begin
                    if (!at_head && (left_value < value_reg))
                        value_next = left_value;
                end
            end
            default:                  value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            value_reg <= oets_pkg::MOST_NEG;
        else
            value_reg <= value_next;
    end

    assign value = value_reg;

endmodule
